[src/xst_pkg.sv]
// Shared constants, codes and request types of the XML stream tokenizer.
package xst_pkg;

  localparam int TOKEN_SIZE = 32;
  localparam int NAME_SIZE  = 16;
  localparam int TAW        = $clog2(TOKEN_SIZE);
  localparam int NAW        = $clog2(NAME_SIZE);
  localparam int KIND_W     = 3;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [KIND_W-1:0] {
    EV_TEXT  = 3'd0,
    EV_START = 3'd1,
    EV_ANAME = 3'd2,
    EV_AVAL  = 3'd3,
    EV_END   = 3'd4,
    EV_DONE  = 3'd5
  } ev_kind_t;

  // Buffer write request from the front part
  typedef struct packed {
    logic           tok_we;
    logic [TAW-1:0] tok_addr;
    logic           name_we;
    logic [NAW-1:0] name_addr;
    logic [7:0]     data;
  } xst_wr_t;

  // Emission request: name, then token, then start complete, each optional
  typedef struct packed {
    logic           emit_name;
    logic [NAW-1:0] name_len;
    logic           emit_tok;
    ev_kind_t       tok_kind;
    logic [TAW-1:0] tok_len;
    logic           emit_done;
    logic           done_sc;
    logic           ovf;
  } xst_cmd_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] ch;
    logic       has_char;
    logic       sc;
    logic       eot;
    logic       last;
    logic       ovf;
  } xst_res_t;

endpackage

[src/xst_front.sv]
// Front part: tokenizer mode machine, buffer writes and emission requests.
module xst_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  output xst_pkg::xst_wr_t  wr,
  output logic              cmd_push,
  output xst_pkg::xst_cmd_t cmd
);
  import xst_pkg::*;

  typedef enum logic [8:0] {
    M_TEXT      = 9'b000000001,
    M_TAGOPEN   = 9'b000000010,
    M_STARTNAME = 9'b000000100,
    M_BETWEEN   = 9'b000001000,
    M_ATTRNAME  = 9'b000010000,
    M_BEFOREVAL = 9'b000100000,
    M_ATTRVAL   = 9'b001000000,
    M_ENDNAME   = 9'b010000000,
    M_SKIP      = 9'b100000000
  } mode_t;

  mode_t          mode, mode_next;
  logic [TAW-1:0] tok_len, tok_len_next;
  logic [NAW-1:0] name_len, name_len_next;
  logic           quote_single, quote_single_next;
  logic           ovf, ovf_next;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  always_comb begin
    logic [TAW-1:0] base;
    logic           do_push;
    logic           do_name;
    logic           emit;
    logic           ws;
    base              = tok_len;
    do_push           = 1'b0;
    do_name           = 1'b0;
    emit              = 1'b0;
    ws                = is_ws(byte_in);
    mode_next         = mode;
    tok_len_next      = tok_len;
    name_len_next     = name_len;
    quote_single_next = quote_single;
    ovf_next          = ovf;
    cmd               = '0;
    cmd.tok_kind      = EV_TEXT;
    wr                = '0;
    wr.data           = byte_in;

    case (mode)
      M_TAGOPEN: begin
        tok_len_next = '0;
        if (byte_in == CH_SLASH) begin
          mode_next = M_ENDNAME;
        end else if (byte_in == CH_BANG || byte_in == CH_QMARK) begin
          mode_next = M_SKIP;
        end else begin
          base      = '0;
          do_push   = 1'b1;
          mode_next = M_STARTNAME;
        end
      end
      M_STARTNAME: begin
        if (ws || byte_in == CH_GT || byte_in == CH_SLASH) begin
          emit         = 1'b1;
          cmd.emit_tok = 1'b1;
          cmd.tok_kind = EV_START;
          cmd.tok_len  = tok_len;
          tok_len_next = '0;
          if (ws) begin
            mode_next = M_BETWEEN;
          end else begin
            cmd.emit_done = 1'b1;
            cmd.done_sc   = (byte_in == CH_SLASH);
            mode_next     = (byte_in == CH_SLASH) ? M_SKIP : M_TEXT;
          end
        end else begin
          do_push = 1'b1;
        end
      end
      M_BETWEEN: begin
        if (ws) begin
          mode_next = M_BETWEEN;
        end else if (byte_in == CH_GT || byte_in == CH_SLASH) begin
          emit          = 1'b1;
          cmd.emit_done = 1'b1;
          cmd.done_sc   = (byte_in == CH_SLASH);
          mode_next     = (byte_in == CH_SLASH) ? M_SKIP : M_TEXT;
        end else begin
          base      = '0;
          do_push   = 1'b1;
          do_name   = 1'b1;
          mode_next = M_ATTRNAME;
        end
      end
      M_ATTRNAME: begin
        if (byte_in == CH_EQ) begin
          // keep the first NAME_SIZE-1 bytes of the name
          if (32'(tok_len) > NAME_SIZE - 1) begin
            name_len_next = NAW'(NAME_SIZE - 1);
          end else begin
            name_len_next = NAW'(tok_len);
          end
          tok_len_next = '0;
          mode_next    = M_BEFOREVAL;
        end else if (!ws) begin
          do_push = 1'b1;
          do_name = 1'b1;
        end
      end
      M_BEFOREVAL: begin
        if (byte_in == CH_DQUOTE || byte_in == CH_SQUOTE) begin
          quote_single_next = (byte_in == CH_SQUOTE);
          mode_next         = M_ATTRVAL;
        end
      end
      M_ATTRVAL: begin
        if (byte_in == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
          emit          = 1'b1;
          cmd.emit_name = 1'b1;
          cmd.name_len  = name_len;
          cmd.emit_tok  = 1'b1;
          cmd.tok_kind  = EV_AVAL;
          cmd.tok_len   = tok_len;
          tok_len_next  = '0;
          mode_next     = M_BETWEEN;
        end else begin
          do_push = 1'b1;
        end
      end
      M_ENDNAME: begin
        if (byte_in == CH_GT) begin
          emit         = 1'b1;
          cmd.emit_tok = 1'b1;
          cmd.tok_kind = EV_END;
          cmd.tok_len  = tok_len;
          tok_len_next = '0;
          mode_next    = M_TEXT;
        end else if (!ws) begin
          do_push = 1'b1;
        end
      end
      M_SKIP: begin
        if (byte_in == CH_GT) begin
          mode_next = M_TEXT;
        end
      end
      default: begin
        if (byte_in == CH_LT) begin
          if (tok_len != '0) begin
            emit         = 1'b1;
            cmd.emit_tok = 1'b1;
            cmd.tok_kind = EV_TEXT;
            cmd.tok_len  = tok_len;
          end
          tok_len_next = '0;
          mode_next    = M_TAGOPEN;
        end else begin
          mode_next = M_TEXT;
          do_push   = 1'b1;
        end
      end
    endcase

    // Append to the token buffer (and to the name buffer for attribute names), or drop and flag overflow when full
    if (do_push) begin
      if (32'(base) + 1 < TOKEN_SIZE) begin
        wr.tok_we    = accept;
        wr.tok_addr  = base;
        tok_len_next = base + 1'b1;
        if (do_name && 32'(base) < NAME_SIZE - 1) begin
          wr.name_we   = accept;
          wr.name_addr = NAW'(base);
        end
      end else begin
        tok_len_next = base;
        ovf_next     = 1'b1;
      end
    end

    cmd.ovf  = ovf_next;
    cmd_push = accept & emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_TEXT;
      tok_len      <= '0;
      name_len     <= '0;
      quote_single <= 1'b0;
      ovf          <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      tok_len      <= tok_len_next;
      name_len     <= name_len_next;
      quote_single <= quote_single_next;
      ovf          <= ovf_next;
    end
  end

endmodule

[src/xst_cmd_q.sv]
// Two-entry queue of emission requests between front and back parts.
module xst_cmd_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xst_pkg::xst_cmd_t din,
  input  logic              pop,
  output logic              empty,
  output xst_pkg::xst_cmd_t dout
);
  import xst_pkg::*;

  xst_cmd_t   entry [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign empty   = (cnt == 2'd0);
  assign do_push = push && (cnt != 2'd2);
  assign do_pop  = pop && !empty;
  assign dout    = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wp] <= din;
  end

endmodule

[src/xst_back.sv]
// Back part: token and name buffers, buffer walk and result register.
module xst_back (
  input  logic              clk,
  input  logic              rst,
  input  xst_pkg::xst_wr_t  wr,
  input  logic              q_empty,
  input  xst_pkg::xst_cmd_t q_cmd,
  output logic              q_pop,
  output logic              busy,
  input  logic              pop,
  output logic              empty,
  output xst_pkg::xst_res_t res
);
  import xst_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_NREAD = 6'b000010,
    B_NPUT  = 6'b000100,
    B_TREAD = 6'b001000,
    B_TPUT  = 6'b010000,
    B_DONE  = 6'b100000
  } bstate_t;

  logic [7:0] tok_mem  [TOKEN_SIZE];
  logic [7:0] name_mem [NAME_SIZE];

  bstate_t        state, state_next;
  xst_cmd_t       cur, cur_next;
  logic [TAW-1:0] tidx, tidx_next;
  logic [NAW-1:0] nidx, nidx_next;
  logic [7:0]     tok_q, name_q;
  xst_res_t       out, out_next;
  logic           out_valid;
  logic           out_load;
  logic           out_free;
  logic           n_eot, t_eot;

  always_ff @(posedge clk) begin
    if (wr.tok_we) tok_mem[wr.tok_addr] <= wr.data;
    if (wr.name_we) name_mem[wr.name_addr] <= wr.data;
    if (state == B_TREAD) tok_q <= tok_mem[tidx];
    if (state == B_NREAD) name_q <= name_mem[nidx];
  end

  assign out_free = !out_valid || pop;
  assign n_eot    = (32'(nidx) + 1 >= 32'(cur.name_len));
  assign t_eot    = (32'(tidx) + 1 >= 32'(cur.tok_len));
  assign busy     = (state != B_IDLE);
  assign empty    = !out_valid;
  assign res      = out;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    tidx_next  = tidx;
    nidx_next  = nidx;
    out_next   = out;
    out_load   = 1'b0;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_next  = q_cmd;
          tidx_next = '0;
          nidx_next = '0;
          if (q_cmd.emit_name) state_next = B_NREAD;
          else if (q_cmd.emit_tok) state_next = B_TREAD;
          else state_next = B_DONE;
        end
      end
      B_NREAD: state_next = B_NPUT;
      B_TREAD: state_next = B_TPUT;
      B_NPUT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next.kind     = EV_ANAME;
          out_next.has_char = (cur.name_len != '0);
          out_next.ch       = (cur.name_len != '0) ? name_q : 8'd0;
          out_next.sc       = 1'b0;
          out_next.eot      = n_eot;
          out_next.last     = n_eot && !cur.emit_tok && !cur.emit_done;
          out_next.ovf      = cur.ovf;
          if (!n_eot) begin
            nidx_next  = nidx + 1'b1;
            state_next = B_NREAD;
          end else if (cur.emit_tok) state_next = B_TREAD;
          else if (cur.emit_done) state_next = B_DONE;
          else state_next = B_IDLE;
        end
      end
      B_TPUT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next.kind     = cur.tok_kind;
          out_next.has_char = (cur.tok_len != '0);
          out_next.ch       = (cur.tok_len != '0) ? tok_q : 8'd0;
          out_next.sc       = 1'b0;
          out_next.eot      = t_eot;
          out_next.last     = t_eot && !cur.emit_done;
          out_next.ovf      = cur.ovf;
          if (!t_eot) begin
            tidx_next  = tidx + 1'b1;
            state_next = B_TREAD;
          end else if (cur.emit_done) state_next = B_DONE;
          else state_next = B_IDLE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next.kind     = EV_DONE;
          out_next.has_char = 1'b0;
          out_next.ch       = 8'd0;
          out_next.sc       = cur.done_sc;
          out_next.eot      = 1'b1;
          out_next.last     = 1'b1;
          out_next.ovf      = cur.ovf;
          state_next        = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    tidx <= tidx_next;
    nidx <= nidx_next;
    if (out_load) out <= out_next;
  end

endmodule

[src/xml_stream_tokenizer_top.sv]
// Top level of the streaming XML tokenizer.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  bytes in | push / full          | byte_in
//  results  | empty / pop          | event_kind, char_out, has_char,
//           |                      | self_closing, end_of_token, last,
//           |                      | overflowed
//
// A byte that ends no token is taken without raising full, so such bytes stream back to back.
// A byte that ends a token raises full until the back part has walked the buffers:
// the back part takes the request, then reports each token item, empty ones included,
// with a read of the single buffer port and then a load of the result register,
// then reports start complete, and it waits on pop.
// Reset (rst, synchronous) returns to text mode with empty buffers and no results.
// A stalled result holds in the result register; the back part waits, the front holds full.
module xml_stream_tokenizer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                byte_in,
  output logic                      empty,
  input  logic                      pop,
  output logic [xst_pkg::KIND_W-1:0] event_kind,
  output logic [7:0]                char_out,
  output logic                      has_char,
  output logic                      self_closing,
  output logic                      end_of_token,
  output logic                      last,
  output logic                      overflowed
);
  import xst_pkg::*;

  logic     accept;
  xst_wr_t  wr;
  logic     cmd_push;
  xst_cmd_t cmd_in, cmd_out;
  logic     q_empty, q_pop;
  logic     back_busy;
  xst_res_t res;

  // Hold new bytes while any emission request is queued or being walked:
  // the buffers must not change under the back part.
  assign full   = !q_empty || back_busy;
  assign accept = push && !full;

  xst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .byte_in  (byte_in),
    .wr       (wr),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  xst_cmd_q u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (cmd_out)
  );

  xst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .q_empty (q_empty),
    .q_cmd   (cmd_out),
    .q_pop   (q_pop),
    .busy    (back_busy),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  // Drive the result ports straight from the result register
  assign event_kind   = res.kind;
  assign char_out     = res.ch;
  assign has_char     = res.has_char;
  assign self_closing = res.sc;
  assign end_of_token = res.eot;
  assign last         = res.last;
  assign overflowed   = res.ovf;

endmodule

[src/xst_checker.sv]
// Port-level checks of the tokenizer, bound to the top level.
module xst_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       push,
  input logic                       full,
  input logic [7:0]                 byte_in,
  input logic                       empty,
  input logic                       pop,
  input logic [xst_pkg::KIND_W-1:0] event_kind,
  input logic [7:0]                 char_out,
  input logic                       has_char,
  input logic                       self_closing,
  input logic                       end_of_token,
  input logic                       last,
  input logic                       overflowed
);
  import xst_pkg::*;

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // Start complete carries no character and closes both token and byte
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind == EV_DONE) |-> (!has_char && end_of_token && last))
    else $error("malformed start complete");

  // Self-closing marks only start complete; last only on a token's end
  a_flags: assert property (@(posedge clk) disable iff (rst)
    (!empty && (self_closing || last)) |->
      ((!self_closing || event_kind == EV_DONE) && (!last || end_of_token)))
    else $error("self_closing or last on wrong item");

  // Overflow is sticky across results
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && overflowed) |=> (empty || overflowed))
    else $error("overflow flag cleared");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(char_out) && $stable(event_kind)))
    else $error("stalled result changed");

endmodule

bind xml_stream_tokenizer_top xst_checker u_xst_checker (.*);
